### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define LSTF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define LSTF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/lstf_pkg.sv
`timescale 1ns / 1ps

package lstf_pkg;

    // Channel and color geometry.
    localparam int CH_W    = 8;
    localparam int LANES   = 3;
    localparam int COLOR_W = CH_W * LANES;
    localparam int PIX_W   = 5;
    localparam int ACT_W   = 6;
    localparam int IN_TW   = 8;
    localparam int OUT_TW  = 32;

    // Configuration port.
    localparam int CFG_AW = 2;
    localparam int CFG_W  = COLOR_W;
    localparam logic [CFG_AW-1:0] CFG_HEAD_COLOR  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_DIM_DIVISOR = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_ACTIVE_LEDS = 2'd2;

    localparam logic [COLOR_W-1:0] RST_HEAD_COLOR  = 24'hFF0000;
    localparam logic [CH_W-1:0]    RST_DIM_DIVISOR = 8'd2;
    localparam logic [ACT_W-1:0]   RST_ACTIVE_LEDS = 6'd32;

    // Divider: quotient bits resolved per cycle.
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = CH_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    typedef enum logic [1:0] {
        PM_KEEP,
        PM_HEAD,
        PM_DIM
    } t_pix_mode;

    typedef struct packed {
        logic      rd_en;
        logic      div_start;
        logic      put;
        logic      last;
        t_pix_mode mode;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

endpackage

### hdl/lstf_div.sv
`timescale 1ns / 1ps

module lstf_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [lstf_pkg::COLOR_W-1:0]     i_num,
    input  logic [lstf_pkg::CH_W-1:0]        i_den,
    output logic                             o_done,
    output logic [lstf_pkg::COLOR_W-1:0]     o_quo
);

    localparam int CH_W  = lstf_pkg::CH_W;
    localparam int LANES = lstf_pkg::LANES;
    localparam logic [lstf_pkg::DIV_CNT_W-1:0] CNT_LAST =
        lstf_pkg::DIV_CNT_W'(lstf_pkg::DIV_CYCLES - 1);

    logic                              r_busy;
    logic                              r_done;
    logic [lstf_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [CH_W-1:0]                   r_den;
    logic [CH_W-1:0]                   r_rem [LANES];
    logic [CH_W-1:0]                   r_num [LANES];
    logic [CH_W-1:0]                   n_rem [LANES];
    logic [CH_W-1:0]                   n_num [LANES];

    // Restoring division, one quotient bit per step; the dividend register
    // shifts out its bits and takes in the quotient bits.
    always_comb begin
        logic [CH_W:0]   t;
        logic [CH_W-1:0] rem;
        logic [CH_W-1:0] num;
        for (int l = 0; l < LANES; l++) begin
            rem = r_rem[l];
            num = r_num[l];
            for (int k = 0; k < lstf_pkg::DIV_STEPS; k++) begin
                t   = {rem, num[CH_W-1]};
                num = {num[CH_W-2:0], 1'b0};
                if (t >= {1'b0, r_den}) begin
                    t      = t - {1'b0, r_den};
                    num[0] = 1'b1;
                end
                rem = t[CH_W-1:0];
            end
            n_rem[l] = rem;
            n_num[l] = num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            for (int l = 0; l < LANES; l++) begin
                r_rem[l] <= '0;
                r_num[l] <= i_num[l*CH_W +: CH_W];
            end
        end else if (r_busy) begin
            for (int l = 0; l < LANES; l++) begin
                r_rem[l] <= n_rem[l];
                r_num[l] <= n_num[l];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l*CH_W +: CH_W] = r_num[l];
        end
    end

    assign o_done = r_done;

endmodule

### hdl/lstf_datapath.sv
`timescale 1ns / 1ps

module lstf_datapath #(
    parameter int MAX_LEDS = 32,
    parameter int IDX_W    = $clog2(MAX_LEDS)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lstf_pkg::CFG_AW-1:0]       i_cfg_idx,
    input  logic [lstf_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  lstf_pkg::t_cmd                    i_cmd,
    input  logic [IDX_W-1:0]                  i_idx,
    output lstf_pkg::t_status                 o_status,
    output logic [IDX_W-1:0]                  o_n_last,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [lstf_pkg::OUT_TW-1:0]       o_m_tdata,
    output logic                              o_m_tlast
);

    localparam int CH_W    = lstf_pkg::CH_W;
    localparam int COLOR_W = lstf_pkg::COLOR_W;
    localparam int PIX_W   = lstf_pkg::PIX_W;
    localparam int ACT_W   = lstf_pkg::ACT_W;
    localparam int NW      = $clog2(MAX_LEDS + 1);
    localparam int CW      = (NW > ACT_W) ? NW : ACT_W;

    logic [COLOR_W-1:0]  r_head_color;
    logic [CH_W-1:0]     r_dim_div;
    logic [ACT_W-1:0]    r_active;

    logic [COLOR_W-1:0]  r_mem [MAX_LEDS];
    logic [MAX_LEDS-1:0] r_valid;
    logic [COLOR_W-1:0]  r_rd_data;
    logic                r_rd_ok;

    logic                r_out_valid;
    logic [lstf_pkg::OUT_TW-1:0] r_out_data;
    logic                r_out_last;

    logic [CW-1:0]       act_ext;
    logic [CW-1:0]       n_len;
    logic [CW-1:0]       n_last_w;
    logic [CH_W-1:0]     den;
    logic [COLOR_W-1:0]  cur_pix;
    logic [COLOR_W-1:0]  new_pix;
    logic [COLOR_W-1:0]  div_quo;
    logic                div_done;
    logic [PIX_W+IDX_W-1:0] idx_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_color <= lstf_pkg::RST_HEAD_COLOR;
            r_dim_div    <= lstf_pkg::RST_DIM_DIVISOR;
            r_active     <= lstf_pkg::RST_ACTIVE_LEDS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lstf_pkg::CFG_HEAD_COLOR:  r_head_color <= i_cfg_wdata;
                lstf_pkg::CFG_DIM_DIVISOR: r_dim_div    <= i_cfg_wdata[CH_W-1:0];
                lstf_pkg::CFG_ACTIVE_LEDS: r_active     <= i_cfg_wdata[ACT_W-1:0];
                default: ;
            endcase
        end
    end

    // Strip length clamped to the range the store supports.
    always_comb begin
        act_ext = CW'(r_active);
        if (act_ext < CW'(2)) begin
            n_len = CW'(2);
        end else if (act_ext > CW'(MAX_LEDS)) begin
            n_len = CW'(MAX_LEDS);
        end else begin
            n_len = act_ext;
        end
        n_last_w = n_len - 1'b1;
    end

    assign o_n_last = n_last_w[IDX_W-1:0];
    assign den      = (r_dim_div == '0) ? CH_W'(1) : r_dim_div;

    // A pixel never written since reset reads as black.
    assign cur_pix = r_rd_ok ? r_rd_data : '0;

    lstf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (cur_pix),
        .i_den   (den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        unique case (i_cmd.mode)
            lstf_pkg::PM_HEAD: new_pix = r_head_color;
            lstf_pkg::PM_DIM:  new_pix = div_quo;
            default:           new_pix = cur_pix;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_idx];
            r_rd_ok   <= r_valid[i_idx];
        end
        if (i_cmd.put) begin
            r_mem[i_idx] <= new_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.put) begin
            r_valid[i_idx] <= 1'b1;
        end
    end

    assign idx_ext = {PIX_W'(0), i_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.put) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_out_data <= lstf_pkg::OUT_TW'({new_pix[CH_W-1:0],
                                             new_pix[2*CH_W-1:CH_W],
                                             new_pix[3*CH_W-1:2*CH_W],
                                             idx_ext[PIX_W-1:0]});
            r_out_last <= i_cmd.last;
        end
    end

    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

### hdl/lstf_ctrl.sv
`timescale 1ns / 1ps

module lstf_ctrl #(
    parameter int MAX_LEDS = 32,
    parameter int IDX_W    = $clog2(MAX_LEDS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        i_step,
    output logic                        o_s_tready,
    input  lstf_pkg::t_status           i_status,
    input  logic [IDX_W-1:0]            i_n_last,
    output lstf_pkg::t_cmd              o_cmd,
    output logic [IDX_W-1:0]            o_idx
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_DIV,
        S_PUT
    } t_state;

    t_state             r_state;
    logic [IDX_W-1:0]   r_head;
    logic               r_sweep;
    logic               r_rev;
    logic [IDX_W-1:0]   r_pos;
    logic [IDX_W-1:0]   r_idx;

    logic [IDX_W:0]     fwd_next;
    logic [IDX_W-1:0]   fwd_pos;
    logic [IDX_W-1:0]   rev_pos;
    logic               is_last;
    lstf_pkg::t_pix_mode mode;

    // Head for this tick; a head left beyond a shortened strip saturates.
    assign fwd_next = {1'b0, r_head} + 1'b1;
    assign fwd_pos  = (fwd_next > {1'b0, i_n_last}) ? i_n_last : fwd_next[IDX_W-1:0];
    assign rev_pos  = (r_head > i_n_last) ? i_n_last : r_head;
    assign is_last  = (r_idx == i_n_last);

    // Forward ticks dim the pixels below the head, reverse ticks those above.
    always_comb begin
        if (r_idx == r_pos) begin
            mode = lstf_pkg::PM_HEAD;
        end else if ((!r_rev && r_idx < r_pos) || (r_rev && r_idx > r_pos)) begin
            mode = lstf_pkg::PM_DIM;
        end else begin
            mode = lstf_pkg::PM_KEEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_sweep <= 1'b0;
            r_rev   <= 1'b0;
            r_pos   <= '0;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid && i_step) begin
                        r_rev <= r_sweep;
                        r_idx <= '0;
                        if (!r_sweep) begin
                            r_pos  <= fwd_pos;
                            r_head <= fwd_pos;
                            if (fwd_pos >= i_n_last) begin
                                r_sweep <= 1'b1;
                            end
                        end else begin
                            r_pos <= rev_pos;
                            if (rev_pos == '0) begin
                                r_head  <= '0;
                                r_sweep <= 1'b0;
                            end else begin
                                r_head <= rev_pos - 1'b1;
                            end
                        end
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_state <= (mode == lstf_pkg::PM_DIM) ? S_DIV : S_PUT;
                end
                S_DIV: begin
                    if (i_status.div_done) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (i_status.out_free) begin
                        if (is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready      = (r_state == S_IDLE);
    assign o_cmd.rd_en     = (r_state == S_READ);
    assign o_cmd.div_start = (r_state == S_LOAD) && (mode == lstf_pkg::PM_DIM);
    assign o_cmd.put       = (r_state == S_PUT) && i_status.out_free;
    assign o_cmd.last      = is_last;
    assign o_cmd.mode      = mode;
    assign o_idx           = r_idx;

`include "assert_macros.svh"

    `LSTF_ASSERT(a_done_in_div, i_clk, i_rst_n, i_status.div_done |-> (r_state == S_DIV), "divider finished outside the divide wait")
    `LSTF_ASSERT(a_div_entry, i_clk, i_rst_n, (r_state == S_DIV) |-> ($past(r_state) == S_LOAD || $past(r_state) == S_DIV), "divide wait entered without a pixel load")
    `LSTF_ASSERT(a_last_idle, i_clk, i_rst_n, (o_cmd.put && o_cmd.last) |=> (r_state == S_IDLE), "frame did not end after its last pixel")

endmodule

### hdl/led_scanner_trail_fade.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake              Payload
// s (step)  in   i_s_tvalid/o_s_tready  i_s_tdata[0] step
// m (pixel) out  o_m_tvalid/i_m_tready  o_m_tdata index, red, green, blue; o_m_tlast
// cfg       in   i_cfg_we               i_cfg_idx, i_cfg_wdata
//
// A step beat with step set produces N pixel beats; each pixel is read, updated and
// written back through the single pixel store port: the head or an untouched pixel
// passes the read, load and put states, a dimmed one also waits in the divide state.
// A step beat with step clear is taken and produces nothing.
// Reset clears the store at once through per-pixel valid bits; no clearing pass.
// A stalled output holds the frame at that pixel; the last beat may wait while
// the next step beat is taken.

module led_scanner_trail_fade #(
    parameter int MAX_LEDS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [lstf_pkg::IN_TW-1:0]     i_s_tdata,   // [0] step
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [lstf_pkg::OUT_TW-1:0]    o_m_tdata,   // [4:0] pixel_index, [12:5] red,
                                                        // [20:13] green, [28:21] blue
    output logic                           o_m_tlast,   // last_pixel
    input  logic                           i_cfg_we,
    input  logic [lstf_pkg::CFG_AW-1:0]    i_cfg_idx,
    input  logic [lstf_pkg::CFG_W-1:0]     i_cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_LEDS);

    lstf_pkg::t_cmd    cmd;
    lstf_pkg::t_status status;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  n_last;

    lstf_ctrl #(
        .MAX_LEDS (MAX_LEDS),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_step     (i_s_tdata[0]),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .i_n_last   (n_last),
        .o_cmd      (cmd),
        .o_idx      (idx)
    );

    lstf_datapath #(
        .MAX_LEDS (MAX_LEDS),
        .IDX_W    (IDX_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .o_status    (status),
        .o_n_last    (n_last),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
